// ===== rtl/rrb_pkg.sv =====
`default_nettype none

package rrb_pkg;

  localparam int RRB_DEPTH    = 32;
  localparam int RRB_SEQ_BITS = 8;

  localparam int SEQ_IN_W = 8;
  localparam int STAMP_W  = 32;
  localparam int REF_W    = 8;
  localparam int LEN_W    = 10;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED,
    ST_DUPLICATE,
    ST_FULL,
    ST_POPPED,
    ST_NOT_READY
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_SCAN,
    S_SHIFT,
    S_INS,
    S_RESP
  } rrb_state_t;

endpackage

`default_nettype wire

// ===== rtl/rrb_in_if.sv =====
`default_nettype none

interface rrb_in_if import rrb_pkg::*;;
  logic                valid;
  logic                ready;
  logic                func;
  logic [SEQ_IN_W-1:0] seq_num;
  logic [SEQ_IN_W-1:0] expected_seq;
  logic [STAMP_W-1:0]  stamp;
  logic [REF_W-1:0]    payload_ref;
  logic [LEN_W-1:0]    payload_len;

  modport source (output valid, func, seq_num, expected_seq, stamp, payload_ref, payload_len,
                  input ready);
  modport sink (input valid, func, seq_num, expected_seq, stamp, payload_ref, payload_len,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/rrb_out_if.sv =====
`default_nettype none

interface rrb_out_if import rrb_pkg::*; #(
  parameter int CNT_W = 6
);
  logic                valid;
  logic                ready;
  status_t             status;
  logic [SEQ_IN_W-1:0] out_seq;
  logic [STAMP_W-1:0]  out_stamp;
  logic [REF_W-1:0]    out_ref;
  logic [LEN_W-1:0]    out_len;
  logic [CNT_W-1:0]    occupancy;

  modport source (output valid, status, out_seq, out_stamp, out_ref, out_len, occupancy,
                  input ready);
  modport sink (input valid, status, out_seq, out_stamp, out_ref, out_len, occupancy,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/receive_reorder_buffer.sv =====
// Receive reorder buffer: holds up to DEPTH packet descriptors in one circular
// RAM, ordered by wrapped distance (seq - expected) mod 2^SEQ_BITS from the head.
// One word is handled at a time. A pop reads the head, decides, then gives its
// result. A push walks the stored entries from the head one RAM read per cycle
// until it finds its slot, then moves the entries from the tail back to that slot
// up by one, one RAM write per cycle. The entry at the slot is read by the walk
// and again by the move. A duplicate goes to the result as soon as the walk
// reaches its match. A push to a full buffer or a pop of an empty one skips the
// RAM and goes straight to the result. The next word is accepted as soon as the
// result sits in the output register.
`default_nettype none

module receive_reorder_buffer import rrb_pkg::*; #(
  parameter int DEPTH    = RRB_DEPTH,
  parameter int SEQ_BITS = RRB_SEQ_BITS,
  localparam int AW = $clog2(DEPTH),
  localparam int WW = SEQ_BITS + STAMP_W + REF_W + LEN_W
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rrb_in_if.sink    in_ch,
  rrb_out_if.source out_ch
);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  rrb_ctrl #(
    .DEPTH    (DEPTH),
    .SEQ_BITS (SEQ_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  rrb_ram #(
    .W (WW),
    .D (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/rrb_ram.sv =====
`default_nettype none

module rrb_ram #(
  parameter int W = 8,
  parameter int D = 32,
  localparam int AW = $clog2(D)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/rrb_ctrl.sv =====
`default_nettype none

module rrb_ctrl import rrb_pkg::*; #(
  parameter int DEPTH    = RRB_DEPTH,
  parameter int SEQ_BITS = RRB_SEQ_BITS,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int WW = SEQ_BITS + STAMP_W + REF_W + LEN_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  rrb_in_if.sink             in_ch,
  rrb_out_if.source          out_ch,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [WW-1:0]      ram_wdata,
  output logic [AW-1:0]      ram_raddr,
  input  wire logic [WW-1:0] ram_rdata
);

  function automatic logic [AW-1:0] inc_a(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] dec_a(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
  endfunction

  // control
  rrb_state_t    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;

  // item and walk registers
  logic                func_r, func_nxt;
  logic [SEQ_BITS-1:0] seq_r, seq_nxt;
  logic [SEQ_BITS-1:0] exp_r, exp_nxt;
  logic [STAMP_W-1:0]  stamp_r, stamp_nxt;
  logic [REF_W-1:0]    ref_r, ref_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [AW-1:0]       phys_r, phys_nxt;
  logic [CW-1:0]       chk_r, chk_nxt;
  logic [AW-1:0]       wr_r, wr_nxt;
  logic [AW-1:0]       rd_r, rd_nxt;
  logic [CW-1:0]       left_r, left_nxt;

  // pending result and output word
  status_t             res_st_r, res_st_nxt;
  logic [SEQ_IN_W-1:0] res_seq_r, res_seq_nxt;
  logic [STAMP_W-1:0]  res_stamp_r, res_stamp_nxt;
  logic [REF_W-1:0]    res_ref_r, res_ref_nxt;
  logic [LEN_W-1:0]    res_len_r, res_len_nxt;
  status_t             o_st_r, o_st_nxt;
  logic [SEQ_IN_W-1:0] o_seq_r, o_seq_nxt;
  logic [STAMP_W-1:0]  o_stamp_r, o_stamp_nxt;
  logic [REF_W-1:0]    o_ref_r, o_ref_nxt;
  logic [LEN_W-1:0]    o_len_r, o_len_nxt;
  logic [CW-1:0]       o_occ_r, o_occ_nxt;

  // fields of the word read last cycle
  logic [SEQ_BITS-1:0] e_seq;
  logic [STAMP_W-1:0]  e_stamp;
  logic [REF_W-1:0]    e_ref;
  logic [LEN_W-1:0]    e_len;
  logic [SEQ_BITS-1:0] d_new;
  logic [SEQ_BITS-1:0] d_ent;

  assign {e_seq, e_stamp, e_ref, e_len} = ram_rdata;
  assign d_new = seq_r - exp_r;
  assign d_ent = e_seq - exp_r;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = o_st_r;
  assign out_ch.out_seq   = o_seq_r;
  assign out_ch.out_stamp = o_stamp_r;
  assign out_ch.out_ref   = o_ref_r;
  assign out_ch.out_len   = o_len_r;
  assign out_ch.occupancy = o_occ_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    func_nxt      = func_r;
    seq_nxt       = seq_r;
    exp_nxt       = exp_r;
    stamp_nxt     = stamp_r;
    ref_nxt       = ref_r;
    len_nxt       = len_r;
    phys_nxt      = phys_r;
    chk_nxt       = chk_r;
    wr_nxt        = wr_r;
    rd_nxt        = rd_r;
    left_nxt      = left_r;
    res_st_nxt    = res_st_r;
    res_seq_nxt   = res_seq_r;
    res_stamp_nxt = res_stamp_r;
    res_ref_nxt   = res_ref_r;
    res_len_nxt   = res_len_r;
    o_st_nxt      = o_st_r;
    o_seq_nxt     = o_seq_r;
    o_stamp_nxt   = o_stamp_r;
    o_ref_nxt     = o_ref_r;
    o_len_nxt     = o_len_r;
    o_occ_nxt     = o_occ_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_r;
    ram_wdata     = {seq_r, stamp_r, ref_r, len_r};
    ram_raddr     = head_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt      = in_ch.func;
          seq_nxt       = SEQ_BITS'(in_ch.seq_num);
          exp_nxt       = SEQ_BITS'(in_ch.expected_seq);
          stamp_nxt     = in_ch.stamp;
          ref_nxt       = in_ch.payload_ref;
          len_nxt       = in_ch.payload_len;
          phys_nxt      = head_r;
          chk_nxt       = '0;
          res_seq_nxt   = '0;
          res_stamp_nxt = '0;
          res_ref_nxt   = '0;
          res_len_nxt   = '0;
          if (in_ch.func == FUNC_POP) begin
            if (count_r == '0) begin
              res_st_nxt = ST_NOT_READY;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_POP_RD;
            end
          end else begin
            if (count_r == CW'(DEPTH)) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end else if (count_r == '0) begin
              wr_nxt    = tail_r;
              state_nxt = S_INS;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_POP_RD: begin
        if (e_seq == exp_r) begin
          res_st_nxt    = ST_POPPED;
          res_seq_nxt   = SEQ_IN_W'(e_seq);
          res_stamp_nxt = e_stamp;
          res_ref_nxt   = e_ref;
          res_len_nxt   = e_len;
          head_nxt      = inc_a(head_r);
          count_nxt     = count_r - 1'b1;
        end else begin
          res_st_nxt = ST_NOT_READY;
        end
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        if (d_new == d_ent) begin
          res_st_nxt = ST_DUPLICATE;
          state_nxt  = S_RESP;
        end else if (d_new < d_ent) begin
          // open a slot: move entries from the tail down to this one up by one
          wr_nxt    = tail_r;
          rd_nxt    = dec_a(tail_r);
          ram_raddr = dec_a(tail_r);
          left_nxt  = count_r - chk_r;
          state_nxt = S_SHIFT;
        end else if (chk_r + 1'b1 == count_r) begin
          wr_nxt    = tail_r;
          state_nxt = S_INS;
        end else begin
          chk_nxt   = chk_r + 1'b1;
          phys_nxt  = inc_a(phys_r);
          ram_raddr = inc_a(phys_r);
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = wr_r;
        ram_wdata = ram_rdata;
        wr_nxt    = rd_r;
        rd_nxt    = dec_a(rd_r);
        ram_raddr = dec_a(rd_r);
        left_nxt  = left_r - 1'b1;
        if (left_r == CW'(1)) begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        ram_we     = 1'b1;
        ram_waddr  = wr_r;
        count_nxt  = count_r + 1'b1;
        tail_nxt   = inc_a(tail_r);
        res_st_nxt = ST_INSERTED;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_st_nxt      = res_st_r;
          o_seq_nxt     = res_seq_r;
          o_stamp_nxt   = res_stamp_r;
          o_ref_nxt     = res_ref_r;
          o_len_nxt     = res_len_r;
          o_occ_nxt     = count_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    seq_r       <= seq_nxt;
    exp_r       <= exp_nxt;
    stamp_r     <= stamp_nxt;
    ref_r       <= ref_nxt;
    len_r       <= len_nxt;
    phys_r      <= phys_nxt;
    chk_r       <= chk_nxt;
    wr_r        <= wr_nxt;
    rd_r        <= rd_nxt;
    left_r      <= left_nxt;
    res_st_r    <= res_st_nxt;
    res_seq_r   <= res_seq_nxt;
    res_stamp_r <= res_stamp_nxt;
    res_ref_r   <= res_ref_nxt;
    res_len_r   <= res_len_nxt;
    o_st_r      <= o_st_nxt;
    o_seq_r     <= o_seq_nxt;
    o_stamp_r   <= o_stamp_nxt;
    o_ref_r     <= o_ref_nxt;
    o_len_r     <= o_len_nxt;
    o_occ_r     <= o_occ_nxt;
  end

endmodule

`default_nettype wire

// ===== bench/rrb_reorder_checker.sv =====
`timescale 1ns / 100ps

module rrb_reorder_checker import rrb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rrb_in_if    in_ch,
  rrb_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  localparam logic [SEQ_IN_W-1:0] SEQ_MASK = SEQ_IN_W'((1 << RRB_SEQ_BITS) - 1);

  typedef struct packed {
    logic [SEQ_IN_W-1:0] seq;
    logic [STAMP_W-1:0]  stamp;
    logic [REF_W-1:0]    pref;
    logic [LEN_W-1:0]    len;
  } pkt_desc_t;

  typedef struct packed {
    status_t             status;
    logic [SEQ_IN_W-1:0] seq;
    logic [STAMP_W-1:0]  stamp;
    logic [REF_W-1:0]    pref;
    logic [LEN_W-1:0]    len;
    logic [5:0]          occ;
  } rrb_result_t;

  pkt_desc_t   held_descs[$];   // buffer contents, head first
  rrb_result_t due_results[$];
  int          mismatches  = 0;
  int          outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  function automatic logic [SEQ_IN_W-1:0] wrap_dist(logic [SEQ_IN_W-1:0] s,
                                                    logic [SEQ_IN_W-1:0] e);
    return (s - e) & SEQ_MASK;
  endfunction

  function automatic rrb_result_t reorder_step(logic f, logic [SEQ_IN_W-1:0] s_in,
                                               logic [SEQ_IN_W-1:0] e_in,
                                               logic [STAMP_W-1:0] st,
                                               logic [REF_W-1:0] r,
                                               logic [LEN_W-1:0] l);
    rrb_result_t         res;
    pkt_desc_t           d;
    logic [SEQ_IN_W-1:0] s;
    logic [SEQ_IN_W-1:0] e;
    logic [SEQ_IN_W-1:0] dn;
    logic [SEQ_IN_W-1:0] de;
    int                  pos;
    int                  i;
    bit                  dup;
    bit                  found;
    res   = '0;
    s     = s_in & SEQ_MASK;
    e     = e_in & SEQ_MASK;
    if (f == FUNC_PUSH) begin
      if (held_descs.size() >= RRB_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        dn    = wrap_dist(s, e);
        pos   = held_descs.size();
        dup   = 1'b0;
        found = 1'b0;
        // walk stops at the first stored entry at equal or larger distance
        for (i = 0; i < held_descs.size() && !found; i++) begin
          de = wrap_dist(held_descs[i].seq, e);
          if (dn == de) begin
            dup   = 1'b1;
            found = 1'b1;
          end else if (dn < de) begin
            pos   = i;
            found = 1'b1;
          end
        end
        if (dup) begin
          res.status = ST_DUPLICATE;
        end else begin
          d.seq   = s;
          d.stamp = st;
          d.pref  = r;
          d.len   = l;
          held_descs.insert(pos, d);
          res.status = ST_INSERTED;
        end
      end
    end else begin
      if (held_descs.size() != 0 && held_descs[0].seq == e) begin
        d          = held_descs.pop_front();
        res.status = ST_POPPED;
        res.seq    = d.seq;
        res.stamp  = d.stamp;
        res.pref   = d.pref;
        res.len    = d.len;
      end else begin
        res.status = ST_NOT_READY;
      end
    end
    res.occ = 6'(held_descs.size());
    return res;
  endfunction

  always @(posedge clk) begin : watch
    rrb_result_t want;
    if (rst_n) begin
      // result side first: a word's own result can never land on its accept edge
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.out_seq !== want.seq) begin
            $error("out_seq: expected %0d, got %0d", want.seq, out_ch.out_seq);
            mismatches++;
          end
          if (out_ch.out_stamp !== want.stamp) begin
            $error("out_stamp: expected %h, got %h", want.stamp, out_ch.out_stamp);
            mismatches++;
          end
          if (out_ch.out_ref !== want.pref) begin
            $error("out_ref: expected %0d, got %0d", want.pref, out_ch.out_ref);
            mismatches++;
          end
          if (out_ch.out_len !== want.len) begin
            $error("out_len: expected %0d, got %0d", want.len, out_ch.out_len);
            mismatches++;
          end
          if (out_ch.occupancy !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, out_ch.occupancy);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(reorder_step(in_ch.func, in_ch.seq_num, in_ch.expected_seq,
                                           in_ch.stamp, in_ch.payload_ref,
                                           in_ch.payload_len));
      end
      outstanding = due_results.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import rrb_pkg::*;

  localparam int N_ITEMS         = 1300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int TAIL_CYCLES     = 2 * RRB_DEPTH;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fails;
  int   outstanding;
  int   words_sent = 0;
  bit   quiet      = 1'b0;   // no idling on either side
  bit   hold_req   = 1'b0;

  always #1 clk = ~clk;

  rrb_in_if  in_ch();
  rrb_out_if out_ch();

  receive_reorder_buffer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rrb_reorder_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fails),
    .pending    (outstanding)
  );

  task automatic send_word(input logic f, input logic [SEQ_IN_W-1:0] s,
                           input logic [SEQ_IN_W-1:0] e, input logic [STAMP_W-1:0] st,
                           input logic [REF_W-1:0] r, input logic [LEN_W-1:0] l);
    if (!quiet && $urandom_range(0, 99) < 28) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (!quiet && $urandom_range(0, 99) < 28);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.seq_num      <= s;
    in_ch.expected_seq <= e;
    in_ch.stamp        <= st;
    in_ch.payload_ref  <= r;
    in_ch.payload_len  <= l;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic push_rand(input logic [SEQ_IN_W-1:0] s, input logic [SEQ_IN_W-1:0] e);
    send_word(FUNC_PUSH, s, e, $urandom(), REF_W'($urandom_range(0, 255)),
              LEN_W'($urandom_range(0, 512)));
  endtask

  task automatic pop_at(input logic [SEQ_IN_W-1:0] e);
    send_word(FUNC_POP, SEQ_IN_W'($urandom_range(0, 255)), e, $urandom(),
              REF_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 512)));
  endtask

  // receiver: random back-pressure plus one long hold-off
  initial begin : rx
    bit hold_done;
    hold_done    = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stim
    logic [SEQ_IN_W-1:0] base;
    int                  burst;
    int                  i;
    int                  j;
    int                  tmp;
    int                  order[$];
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_PUSH;
    in_ch.seq_num      <= '0;
    in_ch.expected_seq <= '0;
    in_ch.stamp        <= '0;
    in_ch.payload_ref  <= '0;
    in_ch.payload_len  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ordering across the sequence wrap, duplicates, head not due, empty pops
    pop_at(8'd0);
    send_word(FUNC_PUSH, 8'd0,   8'd254, 32'h0000_0000, 8'd0,   10'd0);
    send_word(FUNC_PUSH, 8'd254, 8'd254, 32'hFFFF_FFFF, 8'd255, 10'd512);
    send_word(FUNC_PUSH, 8'd1,   8'd254, 32'hA5A5_5A5A, 8'd85,  10'd511);
    send_word(FUNC_PUSH, 8'd255, 8'd254, 32'h5A5A_A5A5, 8'd170, 10'd256);
    push_rand(8'd0, 8'd254);
    pop_at(8'd255);
    pop_at(8'd254);
    pop_at(8'd255);
    pop_at(8'd0);
    pop_at(8'd1);
    pop_at(8'd1);
    // expected number moves between pushes; a new entry can land ahead of the head
    push_rand(8'd20, 8'd0);
    push_rand(8'd30, 8'd25);
    push_rand(8'd20, 8'd25);
    pop_at(8'd30);
    pop_at(8'd20);
    pop_at(8'd20);

    base = 8'd40;
    while (words_sent < N_ITEMS) begin
      quiet = (words_sent >= 350 && words_sent < 600);
      if (words_sent >= 800)
        hold_req = 1'b1;
      if ($urandom_range(0, 99) < 75) begin
        // window of packets arriving out of order, then drained in order
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
        order.delete();
        for (i = 0; i < burst; i++)
          order.push_back(i);
        for (i = burst - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (i = 0; i < burst; i++) begin
          push_rand(SEQ_IN_W'(base + order[i]), base);
          if ($urandom_range(0, 9) == 0)
            push_rand(SEQ_IN_W'(base + order[$urandom_range(0, i)]), base);
          if ($urandom_range(0, 19) == 0)
            push_rand(SEQ_IN_W'($urandom_range(0, 255)), SEQ_IN_W'($urandom_range(0, 255)));
        end
        for (i = 0; i < burst; i++) begin
          if ($urandom_range(0, 19) == 0)
            pop_at(SEQ_IN_W'($urandom_range(0, 255)));
          pop_at(SEQ_IN_W'(base + i));
        end
        base = SEQ_IN_W'(base + burst);
      end else if ($urandom_range(0, 1) == 0) begin
        push_rand(SEQ_IN_W'($urandom_range(0, 255)),
                  ($urandom_range(0, 1) == 0) ? base : SEQ_IN_W'($urandom_range(0, 255)));
      end else begin
        pop_at(($urandom_range(0, 1) == 0) ? base : SEQ_IN_W'($urandom_range(0, 255)));
      end
    end
    in_ch.valid <= 1'b0;

    // one edge so the last accepted word is counted before polling
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
